// ----- rtl/core/kmc_pkg.sv -----
package kmc_pkg;

    localparam int MAX_SAMPLES  = 64;
    localparam int MAX_CLUSTERS = 8;
    localparam int FRAC_BITS    = 16;

    localparam int AW    = $clog2(MAX_SAMPLES);       // sample address
    localparam int NW    = $clog2(MAX_SAMPLES + 1);   // sample count
    localparam int CW    = $clog2(MAX_CLUSTERS);      // cluster number
    localparam int KW    = 4;                         // cluster_count register
    localparam int LIMW  = 8;                         // iteration_limit register
    localparam int RAWW  = 32;                        // raw sample axis
    localparam int NRMW  = FRAC_BITS;                 // normalised axis
    localparam int SUMW  = FRAC_BITS + AW;            // per-cluster axis sum
    localparam int DIVW  = RAWW + FRAC_BITS;          // divider dividend
    localparam int IDXW  = 2;                         // config register index
    localparam int CFGW  = 8;                         // config write data
    localparam int STW   = 2;                         // status code

    localparam logic [STW-1:0]  ST_OK  = 2'd0;
    localparam logic [STW-1:0]  ST_FEW = 2'd1;
    localparam logic [STW-1:0]  ST_OVF = 2'd2;

    localparam logic [IDXW-1:0] REG_CLUSTER_COUNT   = 2'd0;
    localparam logic [IDXW-1:0] REG_ITERATION_LIMIT = 2'd1;

    localparam logic [KW-1:0]   CLUSTER_COUNT_RST   = 4'd2;
    localparam logic [LIMW-1:0] ITERATION_LIMIT_RST = 8'd16;

    typedef struct packed {
        logic [AW-1:0]  addr;
        logic [AW-1:0]  piv_idx;
        logic [NW-1:0]  n;
        logic [KW-1:0]  k;
        logic           raw_we;
        logic           mm_issue;
        logic           mm_first;
        logic           norm_start;
        logic           norm_we;
        logic           piv_latch;
        logic           scan_issue;
        logic           seed_set;
        logic           pt_latch;
        logic           dist_issue;
        logic [CW-1:0]  dist_j;
        logic           acc_clr;
        logic           asg_we;
        logic           upd_start;
        logic           upd_we;
        logic [CW-1:0]  upd_j;
        logic           out_load;
        logic           out_err;
        logic           out_last;
        logic [STW-1:0] err_code;
    } kmc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cnt_zero;
        logic changed;
    } kmc_sts_t;

endpackage

// ----- rtl/core/kmeans_two_axis_cluster_top.sv -----
// Loading: one sample per cycle; a sample that is not the last gives no result.
// Clustering after the last sample is paced mainly by the bit-serial dividers and
//   the one-distance-per-cycle assignment loop.
// Results then leave one at a time, each read and loaded before it is offered; an
//   error result is loaded in S_ERR_LD straight after the last sample, then offered.
// Reset (aresetn, synchronous, active low) clears control and restores the register
//   defaults; sample and centroid stores hold undefined data until written.
module kmeans_two_axis_cluster_top
    import kmc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDXW-1:0]        cfg_index,
    input  logic [CFGW-1:0]        cfg_data,
    // sample requests
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [RAWW-1:0]        s_timestamp,
    input  logic signed [RAWW-1:0] s_reading,
    input  logic                   s_last_sample,
    // result requests
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [AW-1:0]          m_sample_index,
    output logic [CW-1:0]          m_cluster,
    output logic [STW-1:0]         m_status,
    output logic                   m_last_result
);

    kmc_cmd_t cmd;
    kmc_sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: load, normalise, seed, Lloyd rounds, emit
    kmc_ctrl u_ctrl (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_last_sample,
        .m_valid, .m_ready,
        .sts, .cmd
    );

    // stores, dividers, distance pipeline and result register
    kmc_dp u_dp (
        .aclk, .aresetn,
        .s_timestamp, .s_reading,
        .cmd, .sts,
        .out_idx(m_sample_index),
        .out_cluster(m_cluster),
        .out_status(m_status),
        .out_last(m_last_result)
    );

    // never take a sample while a result is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("sample taken while result pending");

    // return to loading once the final result leaves
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> s_ready)
        else $error("no return to loading after final result");

    // an error status stands alone as the final result
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> m_last_result)
        else $error("error result not marked final");

endmodule

// ----- rtl/core/kmc_ram.sv -----
module kmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/kmc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module kmc_div #(
    parameter int DW = 48,
    parameter int VW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   dq_reg, dq_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [VW:0]     trial;
    logic [VW:0]     diff;

    always_comb begin
        trial     = {rem_reg, dq_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            dq_next  = dividend;
            rem_next = '0;
            cnt_next = CNTW'(DW);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[VW-1:0];
                dq_next  = {dq_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[VW-1:0];
                dq_next  = {dq_reg[DW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- rtl/core/kmc_dp.sv -----
module kmc_dp
    import kmc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [RAWW-1:0]        s_timestamp,
    input  logic signed [RAWW-1:0] s_reading,
    input  kmc_cmd_t               cmd,
    output kmc_sts_t               sts,
    output logic [AW-1:0]          out_idx,
    output logic [CW-1:0]          out_cluster,
    output logic [STW-1:0]         out_status,
    output logic                   out_last
);

    logic [RAWW-1:0] t_rd, r_rd;
    logic [NRMW-1:0] nt_rd, nr_rd;
    logic [CW-1:0]   asg_rd;

    logic [RAWW-1:0] tmin_reg, tmax_reg, rmin_reg, rmax_reg;
    logic            mm_v_reg, mm_f_reg;

    logic [DIVW-1:0] qt, qr;
    logic            done_t, done_r;
    logic [DIVW-1:0] dvd_t, dvd_r;
    logic [RAWW-1:0] dvs_t, dvs_r;
    logic [RAWW-1:0] t_rng, r_rng;
    logic [NRMW-1:0] qt_sat, qr_sat, nt_wr, nr_wr;

    logic [RAWW-1:0] piv_t, piv_r;
    logic [NRMW-1:0] piv_nt, piv_nr;
    logic            sc_v_reg;
    logic [AW-1:0]   sc_m_reg;
    logic [NW-1:0]   rank_reg;
    logic            ahead_of_piv;
    logic [10:0]     rank_k;

    logic [NRMW-1:0] cent_t [MAX_CLUSTERS];
    logic [NRMW-1:0] cent_r [MAX_CLUSTERS];

    logic [NRMW-1:0]   pt_reg, pv_reg;
    logic [CW-1:0]     old_reg;
    logic              v1_reg, v2_reg;
    logic [CW-1:0]     j1_reg, j2_reg;
    logic signed [NRMW:0] dt_reg, dv_reg;
    logic signed [2*NRMW+1:0] pr_t, pr_v;
    logic [2*NRMW-1:0] sqt_reg, sqv_reg;
    logic [2*NRMW:0]   dsum;
    logic [2*NRMW:0]   bd_reg;
    logic [CW-1:0]     best_reg;

    logic [SUMW-1:0] sum_t [MAX_CLUSTERS];
    logic [SUMW-1:0] sum_r [MAX_CLUSTERS];
    logic [NW-1:0]   cnt   [MAX_CLUSTERS];
    logic            changed_reg;

    kmc_ram #(.WIDTH(RAWW), .DEPTH(MAX_SAMPLES)) u_time_ram (
        .aclk, .we(cmd.raw_we), .wr_addr(cmd.addr), .wr_data(s_timestamp),
        .rd_addr(cmd.addr), .rd_data(t_rd)
    );
    kmc_ram #(.WIDTH(RAWW), .DEPTH(MAX_SAMPLES)) u_reading_ram (
        .aclk, .we(cmd.raw_we), .wr_addr(cmd.addr), .wr_data(s_reading),
        .rd_addr(cmd.addr), .rd_data(r_rd)
    );
    kmc_ram #(.WIDTH(NRMW), .DEPTH(MAX_SAMPLES)) u_ntime_ram (
        .aclk, .we(cmd.norm_we), .wr_addr(cmd.addr), .wr_data(nt_wr),
        .rd_addr(cmd.addr), .rd_data(nt_rd)
    );
    kmc_ram #(.WIDTH(NRMW), .DEPTH(MAX_SAMPLES)) u_nreading_ram (
        .aclk, .we(cmd.norm_we), .wr_addr(cmd.addr), .wr_data(nr_wr),
        .rd_addr(cmd.addr), .rd_data(nr_rd)
    );
    kmc_ram #(.WIDTH(CW), .DEPTH(MAX_SAMPLES)) u_assign_ram (
        .aclk, .we(cmd.asg_we), .wr_addr(cmd.addr), .wr_data(best_reg),
        .rd_addr(cmd.addr), .rd_data(asg_rd)
    );

    // min and max of both axes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_v_reg <= 1'b0;
        end else begin
            mm_v_reg <= cmd.mm_issue;
        end
    end

    always_ff @(posedge aclk) begin
        mm_f_reg <= cmd.mm_first;
        if (mm_v_reg) begin
            if (mm_f_reg || t_rd < tmin_reg) tmin_reg <= t_rd;
            if (mm_f_reg || t_rd > tmax_reg) tmax_reg <= t_rd;
            if (mm_f_reg || $signed(r_rd) < $signed(rmin_reg)) rmin_reg <= r_rd;
            if (mm_f_reg || $signed(r_rd) > $signed(rmax_reg)) rmax_reg <= r_rd;
        end
    end

    // dividers, shared by normalisation and centroid means
    assign t_rng = tmax_reg - tmin_reg;
    assign r_rng = rmax_reg - rmin_reg;

    always_comb begin
        if (cmd.upd_start) begin
            dvd_t = DIVW'(sum_t[cmd.upd_j]);
            dvd_r = DIVW'(sum_r[cmd.upd_j]);
            dvs_t = RAWW'(cnt[cmd.upd_j]);
            dvs_r = RAWW'(cnt[cmd.upd_j]);
        end else begin
            dvd_t = {t_rd - tmin_reg, {FRAC_BITS{1'b0}}};
            dvd_r = {r_rd - rmin_reg, {FRAC_BITS{1'b0}}};
            dvs_t = t_rng;
            dvs_r = r_rng;
        end
    end

    kmc_div #(.DW(DIVW), .VW(RAWW)) u_div_t (
        .aclk, .aresetn, .start(cmd.norm_start | cmd.upd_start),
        .dividend(dvd_t), .divisor(dvs_t), .done(done_t), .quotient(qt)
    );
    kmc_div #(.DW(DIVW), .VW(RAWW)) u_div_r (
        .aclk, .aresetn, .start(cmd.norm_start | cmd.upd_start),
        .dividend(dvd_r), .divisor(dvs_r), .done(done_r), .quotient(qr)
    );

    // saturate a full-scale quotient
    assign qt_sat = (|qt[DIVW-1:FRAC_BITS]) ? '1 : qt[NRMW-1:0];
    assign qr_sat = (|qr[DIVW-1:FRAC_BITS]) ? '1 : qr[NRMW-1:0];
    assign nt_wr  = (t_rng == '0) ? '0 : qt_sat;
    assign nr_wr  = (r_rng == '0) ? '0 : qr_sat;

    // seed rank: count samples that sort ahead of the pivot
    assign ahead_of_piv = (t_rd < piv_t) ||
                          (t_rd == piv_t && ($signed(r_rd) < $signed(piv_r) ||
                                             (r_rd == piv_r && sc_m_reg < cmd.piv_idx)));
    assign rank_k = 11'(rank_reg) * 11'(cmd.k);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_v_reg <= 1'b0;
        end else begin
            sc_v_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        sc_m_reg <= cmd.addr;
        if (cmd.piv_latch) begin
            piv_t    <= t_rd;
            piv_r    <= r_rd;
            piv_nt   <= nt_rd;
            piv_nr   <= nr_rd;
            rank_reg <= '0;
        end else if (sc_v_reg && ahead_of_piv) begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    // centroids
    always_ff @(posedge aclk) begin
        for (int j = 0; j < MAX_CLUSTERS; j++) begin
            if (cmd.seed_set && KW'(j) < cmd.k &&
                11'(j) * 11'(cmd.n) >= rank_k &&
                11'(j) * 11'(cmd.n) < rank_k + 11'(cmd.k)) begin
                cent_t[j] <= piv_nt;
                cent_r[j] <= piv_nr;
            end
        end
        if (cmd.upd_we) begin
            cent_t[cmd.upd_j] <= qt_sat;
            cent_r[cmd.upd_j] <= qr_sat;
        end
    end

    // distance pipeline: difference, square, sum and compare
    assign pr_t = dt_reg * dt_reg;
    assign pr_v = dv_reg * dv_reg;
    assign dsum = {1'b0, sqt_reg} + {1'b0, sqv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.dist_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pt_latch) begin
            pt_reg  <= nt_rd;
            pv_reg  <= nr_rd;
            old_reg <= asg_rd;
        end
        dt_reg  <= $signed({1'b0, pt_reg}) - $signed({1'b0, cent_t[cmd.dist_j]});
        dv_reg  <= $signed({1'b0, pv_reg}) - $signed({1'b0, cent_r[cmd.dist_j]});
        j1_reg  <= cmd.dist_j;
        sqt_reg <= pr_t[2*NRMW-1:0];
        sqv_reg <= pr_v[2*NRMW-1:0];
        j2_reg  <= j1_reg;
        if (v2_reg && (j2_reg == '0 || dsum < bd_reg)) begin
            bd_reg   <= dsum;
            best_reg <= j2_reg;
        end
    end

    // per-cluster sums for the mean update
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            for (int j = 0; j < MAX_CLUSTERS; j++) begin
                sum_t[j] <= '0;
                sum_r[j] <= '0;
                cnt[j]   <= '0;
            end
            changed_reg <= 1'b0;
        end else if (cmd.asg_we) begin
            sum_t[best_reg] <= sum_t[best_reg] + SUMW'(pt_reg);
            sum_r[best_reg] <= sum_r[best_reg] + SUMW'(pv_reg);
            cnt[best_reg]   <= cnt[best_reg] + 1'b1;
            changed_reg     <= changed_reg | (best_reg != old_reg);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_err) begin
                out_idx     <= '0;
                out_cluster <= '0;
                out_status  <= cmd.err_code;
                out_last    <= 1'b1;
            end else begin
                out_idx     <= cmd.addr;
                out_cluster <= asg_rd;
                out_status  <= ST_OK;
                out_last    <= cmd.out_last;
            end
        end
    end

    assign sts.div_done = done_t & done_r;
    assign sts.cnt_zero = (cnt[cmd.upd_j] == '0);
    assign sts.changed  = changed_reg;

endmodule

// ----- rtl/core/kmc_ctrl.sv -----
module kmc_ctrl
    import kmc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [IDXW-1:0] cfg_index,
    input  logic [CFGW-1:0] cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_last_sample,
    output logic            m_valid,
    input  logic            m_ready,
    input  kmc_sts_t        sts,
    output kmc_cmd_t        cmd
);

    typedef enum logic [19:0] {
        S_LOAD      = 20'h00001,
        S_MINMAX    = 20'h00002,
        S_NORM_RD   = 20'h00004,
        S_NORM_GO   = 20'h00008,
        S_NORM_WAIT = 20'h00010,
        S_SEED_PIV  = 20'h00020,
        S_SEED_LAT  = 20'h00040,
        S_SEED_SCAN = 20'h00080,
        S_SEED_SET  = 20'h00100,
        S_ASG_RD    = 20'h00200,
        S_ASG_LAT   = 20'h00400,
        S_ASG_DIST  = 20'h00800,
        S_ASG_WR    = 20'h01000,
        S_ROUND     = 20'h02000,
        S_UPD_GO    = 20'h04000,
        S_UPD_WAIT  = 20'h08000,
        S_OUT_RD    = 20'h10000,
        S_OUT_LD    = 20'h20000,
        S_OUT_WAIT  = 20'h40000,
        S_ERR_LD    = 20'h80000
    } state_t;

    state_t          state_reg, state_next;
    logic [KW-1:0]   kcfg_reg, kcfg_next;
    logic [LIMW-1:0] lcfg_reg, lcfg_next;
    logic [NW-1:0]   n_reg, n_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [NW-1:0]   m_reg, m_next;
    logic [KW-1:0]   j_reg, j_next;
    logic [LIMW-1:0] it_reg, it_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [LIMW-1:0] lim_reg, lim_next;
    logic [STW-1:0]  err_reg, err_next;
    logic            last_reg, last_next;
    logic [KW-1:0]   k_eff;
    logic [LIMW-1:0] lim_eff;
    logic [NW-1:0]   n_tmp;
    logic            ovf_tmp;
    logic            i_last;

    assign k_eff   = (kcfg_reg == '0) ? KW'(1) :
                     (kcfg_reg > KW'(MAX_CLUSTERS)) ? KW'(MAX_CLUSTERS) : kcfg_reg;
    assign lim_eff = (lcfg_reg == '0) ? LIMW'(1) : lcfg_reg;
    assign i_last  = ({1'b0, i_reg} == n_reg - 1'b1);

    always_comb begin
        kcfg_next = kcfg_reg;
        lcfg_next = lcfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CLUSTER_COUNT:   kcfg_next = cfg_data[KW-1:0];
                REG_ITERATION_LIMIT: lcfg_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        it_next    = it_reg;
        k_next     = k_reg;
        lim_next   = lim_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        n_tmp      = n_reg;
        ovf_tmp    = ovf_reg;

        cmd            = '0;
        cmd.addr       = i_reg;
        cmd.piv_idx    = i_reg;
        cmd.n          = n_reg;
        cmd.k          = k_reg;
        cmd.dist_j     = j_reg[CW-1:0];
        cmd.upd_j      = j_reg[CW-1:0];
        cmd.err_code   = err_reg;
        cmd.out_last   = i_last;

        case (state_reg)
            S_LOAD: begin
                cmd.addr = n_reg[AW-1:0];
                if (s_valid) begin
                    if (n_reg == NW'(MAX_SAMPLES)) begin
                        ovf_tmp = 1'b1;
                    end else begin
                        cmd.raw_we = 1'b1;
                        n_tmp      = n_reg + 1'b1;
                    end
                    n_next   = n_tmp;
                    ovf_next = ovf_tmp;
                    if (s_last_sample) begin
                        k_next   = k_eff;
                        lim_next = lim_eff;
                        m_next   = '0;
                        if (ovf_tmp) begin
                            err_next   = ST_OVF;
                            state_next = S_ERR_LD;
                        end else if (NW'(k_eff) > n_tmp) begin
                            err_next   = ST_FEW;
                            state_next = S_ERR_LD;
                        end else begin
                            state_next = S_MINMAX;
                        end
                    end
                end
            end
            S_MINMAX: begin
                cmd.addr     = m_reg[AW-1:0];
                cmd.mm_issue = (m_reg < n_reg);
                cmd.mm_first = (m_reg == '0);
                m_next       = m_reg + 1'b1;
                if (m_reg == n_reg) begin
                    i_next     = '0;
                    state_next = S_NORM_RD;
                end
            end
            S_NORM_RD: state_next = S_NORM_GO;
            S_NORM_GO: begin
                cmd.norm_start = 1'b1;
                state_next     = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (sts.div_done) begin
                    cmd.norm_we = 1'b1;
                    i_next      = i_last ? '0 : i_reg + 1'b1;
                    state_next  = i_last ? S_SEED_PIV : S_NORM_RD;
                end
            end
            S_SEED_PIV: state_next = S_SEED_LAT;
            S_SEED_LAT: begin
                cmd.piv_latch = 1'b1;
                m_next        = '0;
                state_next    = S_SEED_SCAN;
            end
            S_SEED_SCAN: begin
                cmd.addr       = m_reg[AW-1:0];
                cmd.scan_issue = (m_reg < n_reg);
                m_next         = m_reg + 1'b1;
                if (m_reg == n_reg) begin
                    state_next = S_SEED_SET;
                end
            end
            S_SEED_SET: begin
                cmd.seed_set = 1'b1;
                i_next       = i_last ? '0 : i_reg + 1'b1;
                it_next      = '0;
                state_next   = i_last ? S_ASG_RD : S_SEED_PIV;
            end
            S_ASG_RD: begin
                cmd.acc_clr = (i_reg == '0);
                state_next  = S_ASG_LAT;
            end
            S_ASG_LAT: begin
                cmd.pt_latch = 1'b1;
                j_next       = '0;
                state_next   = S_ASG_DIST;
            end
            S_ASG_DIST: begin
                cmd.dist_issue = (j_reg < k_reg);
                j_next         = j_reg + 1'b1;
                if (j_reg == k_reg + 1'b1) begin
                    state_next = S_ASG_WR;
                end
            end
            S_ASG_WR: begin
                cmd.asg_we = 1'b1;
                i_next     = i_last ? '0 : i_reg + 1'b1;
                state_next = i_last ? S_ROUND : S_ASG_RD;
            end
            S_ROUND: begin
                if ((it_reg != '0 && !sts.changed) || it_reg + 1'b1 == lim_reg) begin
                    i_next     = '0;
                    state_next = S_OUT_RD;
                end else begin
                    it_next    = it_reg + 1'b1;
                    j_next     = '0;
                    state_next = S_UPD_GO;
                end
            end
            S_UPD_GO: begin
                if (j_reg == k_reg) begin
                    i_next     = '0;
                    state_next = S_ASG_RD;
                end else if (sts.cnt_zero) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    cmd.upd_start = 1'b1;
                    state_next    = S_UPD_WAIT;
                end
            end
            S_UPD_WAIT: begin
                if (sts.div_done) begin
                    cmd.upd_we = 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = S_UPD_GO;
                end
            end
            S_OUT_RD: state_next = S_OUT_LD;
            S_OUT_LD: begin
                cmd.out_load = 1'b1;
                last_next    = i_last;
                state_next   = S_OUT_WAIT;
            end
            S_ERR_LD: begin
                cmd.out_load = 1'b1;
                cmd.out_err  = 1'b1;
                last_next    = 1'b1;
                state_next   = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        n_next     = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            kcfg_reg  <= CLUSTER_COUNT_RST;
            lcfg_reg  <= ITERATION_LIMIT_RST;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            m_reg     <= '0;
            j_reg     <= '0;
            it_reg    <= '0;
            k_reg     <= '0;
            lim_reg   <= '0;
            err_reg   <= ST_OK;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            kcfg_reg  <= kcfg_next;
            lcfg_reg  <= lcfg_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            m_reg     <= m_next;
            j_reg     <= j_next;
            it_reg    <= it_next;
            k_reg     <= k_next;
            lim_reg   <= lim_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
        end
    end

    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = (state_reg == S_OUT_WAIT);

endmodule
